>>> sv/sati_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sati_pkg
// Shared constants for the sorted address table: default sizes and the
// packing of the stream payloads.
// ----------------------------------------------------------------------------
package sati_pkg;

    localparam int DEFAULT_TABLE_DEPTH   = 16;
    localparam int DEFAULT_ADDRESS_WIDTH = 32;

    // Input payload: break_address.
    localparam int IN_DATA_W  = 32;

    // Result payload: slot_index, already_present, table_full, zero fill.
    localparam int SLOT_W     = 4;
    localparam int OUT_DATA_W = 8;
    localparam int FOUND_BIT  = SLOT_W;
    localparam int FULL_BIT   = SLOT_W + 1;

endpackage

>>> sv/sati_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sati_cell
// One slot of the sorted table: holds one address, compares it with the
// broadcast address and, on an insert, takes the new address or the entry of
// its upper neighbor.
// ----------------------------------------------------------------------------
module sati_cell #(
    parameter int ADDRESS_WIDTH = sati_pkg::DEFAULT_ADDRESS_WIDTH
) (
    input  logic                     aclk,
    input  logic                     load_en,
    input  logic                     occupied,
    input  logic [ADDRESS_WIDTH-1:0] key,
    input  logic [ADDRESS_WIDTH-1:0] prev_entry,
    input  logic                     prev_open,
    output logic [ADDRESS_WIDTH-1:0] entry,
    output logic                     open,
    output logic                     head,
    output logic                     match
);
    import sati_pkg::*;

    logic [ADDRESS_WIDTH-1:0] entry_reg;

    // A slot is open when the key belongs here or further up the table.
    // Because the table is sorted, the open slots form a suffix.
    assign open  = !(occupied && (entry_reg > key));
    assign head  = open && !prev_open;
    assign match = occupied && (entry_reg == key);
    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (load_en && open) begin
            entry_reg <= prev_open ? prev_entry : key;
        end
    end

endmodule

>>> sv/sati_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sati_chain
// Row of table cells. Finds the slot of the key (match or insert point) and
// shifts the lower entries down by one slot on an insert.
// ----------------------------------------------------------------------------
module sati_chain #(
    parameter int TABLE_DEPTH   = sati_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDRESS_WIDTH = sati_pkg::DEFAULT_ADDRESS_WIDTH,
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     load_en,
    input  logic [CNT_W-1:0]         count,
    input  logic [ADDRESS_WIDTH-1:0] key,
    output logic                     found,
    output logic [IDX_W-1:0]         pos
);
    import sati_pkg::*;

    logic [ADDRESS_WIDTH-1:0] entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   open;
    logic [TABLE_DEPTH-1:0]   head;
    logic [TABLE_DEPTH-1:0]   match;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [ADDRESS_WIDTH-1:0] prev_entry;
        logic                     prev_open;

        if (i == 0) begin : g_first
            assign prev_entry = key;
            assign prev_open  = 1'b0;
        end else begin : g_rest
            assign prev_entry = entry[i-1];
            assign prev_open  = open[i-1];
        end

        sati_cell #(
            .ADDRESS_WIDTH (ADDRESS_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .load_en    (load_en),
            .occupied   (CNT_W'(i) < count),
            .key        (key),
            .prev_entry (prev_entry),
            .prev_open  (prev_open),
            .entry      (entry[i]),
            .open       (open[i]),
            .head       (head[i]),
            .match      (match[i])
        );
    end

    assign found = |match;

    // At most one cell is the head of the open suffix; a found key sits
    // exactly there, since every slot before it holds a larger address.
    always_comb begin
        pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (head[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

endmodule

>>> sv/sorted_address_table_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_address_table_insert
// Table of distinct addresses kept sorted by decreasing value.
// ----------------------------------------------------------------------------
// Each transfer on the s_axis channel brings one address. The block looks it
// up in a row of compare cells: if it is present, the result carries its slot
// with already_present set; otherwise it is inserted before the first smaller
// address, the later entries move down one slot and the result carries the
// new slot. An absent address arriving at a full table leaves the table as it
// is and returns slot 0 with table_full set.
// Exactly one result transfer leaves on m_axis for each input transfer, in the
// cycle after acceptance, from an output register. Search, shift and count
// update all complete on acceptance, so a new address is accepted every cycle
// as long as the result is taken.
// When the receiver stalls, the result register holds and s_axis_tready stays
// low until the result is taken; the next input is then accepted in the same
// cycle the held result leaves.
// Reset empties the table (entry count zero) and drops the output valid; the
// block accepts input in the first cycle after reset.
// ----------------------------------------------------------------------------
module sorted_address_table_insert #(
    parameter int TABLE_DEPTH   = sati_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDRESS_WIDTH = sati_pkg::DEFAULT_ADDRESS_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] break_address
    input  logic [sati_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] slot_index, [4] already_present, [5] table_full, [7:6] zero
    output logic [sati_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import sati_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    logic                     in_xfer;
    logic [IN_DATA_W+63:0]    data_ext;
    logic [ADDRESS_WIDTH-1:0] key;
    logic                     found;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W+SLOT_W-1:0]  pos_ext;
    logic                     is_full;
    logic                     reject;
    logic                     insert_en;

    assign s_axis_tready = !m_tvalid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Input bits above the address width are ignored; a wider address is
    // zero extended.
    assign data_ext = {64'd0, s_axis_tdata};
    assign key      = data_ext[ADDRESS_WIDTH-1:0];

    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign reject    = !found && is_full;
    assign insert_en = in_xfer && !found && !is_full;

    sati_chain #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_chain (
        .aclk    (aclk),
        .load_en (insert_en),
        .count   (count_reg),
        .key     (key),
        .found   (found),
        .pos     (pos)
    );

    assign pos_ext = {{SLOT_W{1'b0}}, pos};

    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (insert_en) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (in_xfer) begin
            m_tvalid_next                = 1'b1;
            m_tdata_next                 = '0;
            m_tdata_next[SLOT_W-1:0]     = reject ? '0 : pos_ext[SLOT_W-1:0];
            m_tdata_next[FOUND_BIT]      = found;
            m_tdata_next[FULL_BIT]       = reject;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A rejected or found address leaves the entry count unchanged.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && (found || is_full) |=> $stable(count_reg))
        else $error("entry count changed without an insert");

    // Every accepted address yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_axis_tvalid)
        else $error("no result after an accepted transfer");

    // A result is never both found and rejected.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[FOUND_BIT] && m_axis_tdata[FULL_BIT]))
        else $error("already_present and table_full both set");

endmodule
